>>> rtl/mpd_pkg.sv
// shared types and constants for the maximin pairwise distance block
// no dependencies
package mpd_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned MAX_FACTORS_DEF = 16;
  localparam int unsigned LEVEL_BITS_DEF  = 8;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned PIDX_W  = 6;
  localparam int unsigned FIDX_W  = 4;
  localparam int unsigned NP_W    = 7;
  localparam int unsigned NF_W    = 5;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned OUT_W   = 24;

  localparam logic [OUT_W-1:0] START_MIN = 24'd9999999;
  localparam logic [NP_W-1:0]  NP_RESET  = 7'd64;
  localparam logic [NF_W-1:0]  NF_RESET  = 5'd16;

  typedef enum logic {
    CFG_NUM_POINTS  = 1'b0,
    CFG_NUM_FACTORS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } mpd_state_e;

  // control that travels alongside each store read
  typedef struct packed {
    logic valid;
    logic first;   // first factor of a pair
    logic last;    // last factor of a pair
    logic final_w; // last read of the walk
    logic zero;    // no factors in use, pair sum is zero
    logic bypass;  // no pairs, emit running min as is
  } mpd_tag_t;

endpackage

>>> rtl/mpd_store.sv
// design store: one write port, two registered read ports
// depends on mpd_pkg
module mpd_store import mpd_pkg::*; #(
  parameter int unsigned DEPTH = MAX_POINTS_DEF * MAX_FACTORS_DEF,
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [LEVEL_BITS-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_a_i,
  input  logic [AW-1:0]         raddr_b_i,
  output logic [LEVEL_BITS-1:0] rdata_a_o,
  output logic [LEVEL_BITS-1:0] rdata_b_o
);

  logic [LEVEL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> rtl/mpd_seq.sv
// sequencer: config registers, store write addressing and the pair/factor walk
// depends on mpd_pkg
module mpd_seq import mpd_pkg::*; #(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned MAX_FACTORS = MAX_FACTORS_DEF,
  parameter int unsigned LEVEL_BITS  = LEVEL_BITS_DEF,
  localparam int unsigned AW  = $clog2(MAX_POINTS * MAX_FACTORS),
  localparam int unsigned NPW = $clog2(MAX_POINTS + 1),
  localparam int unsigned NFW = $clog2(MAX_FACTORS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [LEVEL_W-1:0]    level_i,
  input  logic [PIDX_W-1:0]     point_index_i,
  input  logic [FIDX_W-1:0]     factor_index_i,
  input  logic                  last_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  walk_done_i,
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output logic [LEVEL_BITS-1:0] wdata_o,
  output logic [AW-1:0]         raddr_a_o,
  output logic [AW-1:0]         raddr_b_o,
  output mpd_tag_t              tag_o
);

  mpd_state_e state_q, state_d;
  logic [NP_W-1:0] np_cfg_q;
  logic [NF_W-1:0] nf_cfg_q;
  logic [NPW-1:0]  a_q, a_d, b_q, b_d, np_m1_q, np_m1_d;
  logic [NFW-1:0]  f_q, f_d, fmax_q, fmax_d;
  logic            zero_q, zero_d;
  logic [AW-1:0]   base_a_q, base_a_d, base_b_q, base_b_d;

  logic            accept;
  logic [NPW-1:0]  np_eff;
  logic [NFW-1:0]  nf_eff;
  logic            f_last, b_last, is_final;

  assign accept = start && !busy;
  assign busy   = !state_q[0];

  // store write, out of range indexes write nothing
  assign we_o    = accept && (int'(point_index_i) < MAX_POINTS)
                          && (int'(factor_index_i) < MAX_FACTORS);
  assign waddr_o = AW'(int'(point_index_i) * MAX_FACTORS + int'(factor_index_i));
  assign wdata_o = LEVEL_BITS'(level_i);

  assign np_eff = (int'(np_cfg_q) > MAX_POINTS) ? NPW'(MAX_POINTS) : NPW'(np_cfg_q);
  assign nf_eff = (int'(nf_cfg_q) > MAX_FACTORS) ? NFW'(MAX_FACTORS) : NFW'(nf_cfg_q);

  assign raddr_a_o = base_a_q + AW'(f_q);
  assign raddr_b_o = base_b_q + AW'(f_q);

  assign f_last   = (f_q == fmax_q);
  assign b_last   = (b_q == np_m1_q);
  assign is_final = f_last && b_last && (b_q == a_q + NPW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_cfg_q <= NP_RESET;
      nf_cfg_q <= NF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_POINTS:  np_cfg_q <= cfg_wdata_i[NP_W-1:0];
        CFG_NUM_FACTORS: nf_cfg_q <= cfg_wdata_i[NF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    a_d      = a_q;
    b_d      = b_q;
    f_d      = f_q;
    np_m1_d  = np_m1_q;
    fmax_d   = fmax_q;
    zero_d   = zero_q;
    base_a_d = base_a_q;
    base_b_d = base_b_q;
    tag_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_i) begin
          np_m1_d  = np_eff - NPW'(1);
          zero_d   = (nf_eff == '0);
          fmax_d   = (nf_eff == '0) ? '0 : nf_eff - NFW'(1);
          a_d      = '0;
          b_d      = NPW'(1);
          f_d      = '0;
          base_a_d = '0;
          base_b_d = AW'(MAX_FACTORS);
          if (np_eff < NPW'(2)) begin
            // no pair exists, send a lone marker down the pipe
            tag_o.valid   = 1'b1;
            tag_o.final_w = 1'b1;
            tag_o.bypass  = 1'b1;
            state_d       = ST_DRAIN;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        tag_o.valid   = 1'b1;
        tag_o.first   = (f_q == '0);
        tag_o.last    = f_last;
        tag_o.final_w = is_final;
        tag_o.zero    = zero_q;
        if (!f_last) begin
          f_d = f_q + NFW'(1);
        end else begin
          f_d = '0;
          if (!b_last) begin
            b_d      = b_q + NPW'(1);
            base_b_d = base_b_q + AW'(MAX_FACTORS);
          end else begin
            a_d      = a_q + NPW'(1);
            b_d      = a_q + NPW'(2);
            base_a_d = base_a_q + AW'(MAX_FACTORS);
            base_b_d = base_a_q + AW'(2 * MAX_FACTORS);
          end
        end
        if (is_final) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (walk_done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    f_q      <= f_d;
    np_m1_q  <= np_m1_d;
    fmax_q   <= fmax_d;
    zero_q   <= zero_d;
    base_a_q <= base_a_d;
    base_b_q <= base_b_d;
  end

`ifndef SYNTHESIS
  a_final_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && is_final) |=> (state_q == ST_DRAIN))
    else $error("walk did not end after its final read");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (b_q > a_q && b_q <= np_m1_q))
    else $error("pair counters out of order");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && f_q != '0) |-> $stable(a_q) && $stable(b_q))
    else $error("pair moved inside a factor sweep");
`endif

endmodule

>>> rtl/mpd_dp.sv
// datapath: difference, square, saturating pair sum and running minimum
// depends on mpd_pkg
module mpd_dp import mpd_pkg::*; #(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpd_tag_t              tag_i,
  input  logic [LEVEL_BITS-1:0] x_i,
  input  logic [LEVEL_BITS-1:0] y_i,
  output logic                  walk_done_o,
  output logic                  result_valid_o,
  output logic [OUT_W-1:0]      min_sq_dist_o
);

  localparam int unsigned SQ_W  = 2 * LEVEL_BITS;
  localparam int unsigned SUM_W = ((SQ_W > OUT_W) ? SQ_W : OUT_W) + 1;

  mpd_tag_t              tag1_q, tag2_q, tag3_q;
  logic [LEVEL_BITS-1:0] d_q, d_d;
  logic [SQ_W-1:0]       sq_q;
  logic [OUT_W-1:0]      acc_q, acc_d, min_q, min_d, min_new, out_d;
  logic [SUM_W-1:0]      sum;
  logic                  valid_d;

  // store read data lines up with tag1
  always_comb begin
    d_d = (x_i > y_i) ? x_i - y_i : y_i - x_i;
    if (tag1_q.zero) begin
      d_d = '0;
    end
  end

  always_comb begin
    sum     = SUM_W'(tag3_q.first ? '0 : acc_q) + SUM_W'(sq_q);
    acc_d   = (sum > SUM_W'(START_MIN)) ? START_MIN : sum[OUT_W-1:0];
    min_new = (acc_d < min_q) ? acc_d : min_q;
    min_d   = min_q;
    out_d   = min_sq_dist_o;
    valid_d = 1'b0;
    if (tag3_q.valid && tag3_q.last) begin
      min_d = min_new;
    end
    if (tag3_q.valid && tag3_q.final_w) begin
      valid_d = 1'b1;
      out_d   = tag3_q.bypass ? min_q : min_new;
      min_d   = START_MIN;
    end
  end

  assign walk_done_o = tag3_q.valid && tag3_q.final_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q         <= '0;
      tag2_q         <= '0;
      tag3_q         <= '0;
      min_q          <= START_MIN;
      result_valid_o <= 1'b0;
    end else begin
      tag1_q         <= tag_i;
      tag2_q         <= tag1_q;
      tag3_q         <= tag2_q;
      min_q          <= min_d;
      result_valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q           <= d_d;
    sq_q          <= SQ_W'(d_q) * SQ_W'(d_q);
    min_sq_dist_o <= out_d;
    if (tag3_q.valid) begin
      acc_q <= acc_d;
    end
  end

`ifndef SYNTHESIS
  a_min_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (min_q == START_MIN))
    else $error("running min not restarted after a result");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (min_sq_dist_o <= START_MIN))
    else $error("result above start value");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done_o |=> result_valid_o)
    else $error("walk end gave no result");
`endif

endmodule

>>> rtl/maximin_pairwise_distance_top.sv
// maximin pairwise distance: smallest squared euclidean distance over point pairs
// loading: one word per cycle into the design store while not busy; a word without last is
// done next cycle; walk: np*(np-1)/2 pairs times max(nf,1) factors, one store read pair per
// cycle, then the read/difference/square/sum pipeline; fewer than two points gives a result
// with no walk; busy holds off start for walk and drain; the result strobe lasts one cycle
// and cannot stall; reset clears control, config and running min, not the design store
module maximin_pairwise_distance_top import mpd_pkg::*; #(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned MAX_FACTORS = MAX_FACTORS_DEF,
  parameter int unsigned LEVEL_BITS  = LEVEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [PIDX_W-1:0]  point_index_i,
  input  logic [FIDX_W-1:0]  factor_index_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               result_valid_o,
  output logic [OUT_W-1:0]   min_sq_dist_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS * MAX_FACTORS);

  logic                  we, walk_done;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [LEVEL_BITS-1:0] wdata, rdata_a, rdata_b;
  mpd_tag_t              tag;

  mpd_seq #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_FACTORS(MAX_FACTORS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .level_i       (level_i),
    .point_index_i (point_index_i),
    .factor_index_i(factor_index_i),
    .last_i        (last_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .walk_done_i   (walk_done),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_a_o     (raddr_a),
    .raddr_b_o     (raddr_b),
    .tag_o         (tag)
  );

  mpd_store #(
    .DEPTH     (MAX_POINTS * MAX_FACTORS),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  mpd_dp #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (tag),
    .x_i           (rdata_a),
    .y_i           (rdata_b),
    .walk_done_o   (walk_done),
    .result_valid_o(result_valid_o),
    .min_sq_dist_o (min_sq_dist_o)
  );

endmodule
